// ===== rtl/core/paced_queue_red_admission_top_defines.svh =====
// Assertion macros for the paced admission queue checker.
// Used by pqra_checker.sv; no other dependencies.
`ifndef PACED_QUEUE_RED_ADMISSION_TOP_DEFINES_SVH
`define PACED_QUEUE_RED_ADMISSION_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define PQRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pqra assertion failed");

// Next-cycle implication, quiet while reset is held.
`define PQRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pqra assertion failed");

`endif

// ===== rtl/core/pqra_pkg.sv =====
// Shared widths, codes and controller/datapath interface types.
// No dependencies; used by every pqra module.
`default_nettype none
package pqra_pkg;
    localparam int RATE_W  = 22;
    localparam int TPS_W   = 10;
    localparam int LIMP_W  = 11;
    localparam int MINP_W  = 10;
    localparam int BYTES_W = 20;
    localparam int PKTS_W  = 11;
    localparam int TAG_W   = 16;
    localparam int LEN_W   = 14;
    localparam int RND_W   = 8;
    localparam int NOW_W   = 32;
    localparam int CNT32_W = 32;
    localparam int VERD_W  = 3;
    localparam int DIVD_W  = RATE_W + 1;
    localparam int DCNT_W  = $clog2(DIVD_W + 1);
    localparam int CFGA_W  = 3;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 160;

    localparam logic [CFGA_W-1:0] REG_RATE  = 3'd0;
    localparam logic [CFGA_W-1:0] REG_TPS   = 3'd1;
    localparam logic [CFGA_W-1:0] REG_LIMP  = 3'd2;
    localparam logic [CFGA_W-1:0] REG_MINP  = 3'd3;
    localparam logic [CFGA_W-1:0] REG_LIMB  = 3'd4;
    localparam logic [CFGA_W-1:0] REG_MINB  = 3'd5;

    localparam logic [RATE_W-1:0]  RATE_RST = 22'd320;
    localparam logic [TPS_W-1:0]   TPS_RST  = 10'd250;
    localparam logic [LIMP_W-1:0]  LIMP_RST = 11'd1024;
    localparam logic [MINP_W-1:0]  MINP_RST = 10'd512;
    localparam logic [BYTES_W-1:0] LIMB_RST = 20'd49152;
    localparam logic [BYTES_W-1:0] MINB_RST = 20'd12288;

    localparam logic [VERD_W-1:0] V_PASS     = 3'd0;
    localparam logic [VERD_W-1:0] V_QUEUED   = 3'd1;
    localparam logic [VERD_W-1:0] V_HARD     = 3'd2;
    localparam logic [VERD_W-1:0] V_CONG     = 3'd3;
    localparam logic [VERD_W-1:0] V_RELEASED = 3'd4;
    localparam logic [VERD_W-1:0] V_NONE     = 3'd5;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_sel_len;
        logic save_q;
        logic save_l;
        logic eval;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic poll;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/core/paced_queue_red_admission_top.sv =====
// Paced admission queue with random early drop: top level.
// The block shapes packets to bytes_per_tick and answers every item with one verdict.
// Slave stream: one item per transfer, tuser bit 0 selects enqueue (0) or poll (1).
// Master stream: one result per item, verdict in tuser.
// Configuration: write enable, register index, data; write only while the block is idle (not enforced).
// An enqueue goes from its transfer to its result through two runs of a 23-step
// restoring divider (the paced quotient and remainder, then length modulo rate), each
// with a start step and a step that saves the result, plus evaluate and commit steps.
// A poll takes the start, evaluate and commit steps only. The input is ready again
// in the cycle after the commit.
// One item is in work at a time; the next is taken once the result sits in the
// output register, so a waiting result does not block the next item's work, only
// its commit, which holds until the receiver takes the earlier result.
// Reset (synchronous, active low) loads the register defaults, empties the queue,
// clears averages and counters and sets the pacing tick to minus ticks_per_second.
// The descriptor memory holds no reset; only occupied entries are read.
// Depends on pqra_pkg, pqra_ctrl, pqra_dp and pqra_div.
`default_nettype none
module paced_queue_red_admission_top #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int TICK_BITS   = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [pqra_pkg::CFGA_W-1:0]        i_cfg_addr,
    input  wire  [pqra_pkg::RATE_W-1:0]        i_cfg_wdata,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // now_tick[31:0], pkt_tag[47:32], pkt_len[61:48], rand_bytes_level[69:62],
    // rand_pkts_level[77:70], zero[79:78]
    input  wire  [pqra_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // mode[0], is_lldp[1]
    input  wire  [pqra_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // out_tag[15:0], out_len[29:16], release_tick[61:30], queued_pkts[72:62],
    // queued_bytes[92:73], overloaded[93], hard_drops[125:94],
    // congestion_drops[157:126], zero[159:158]
    output logic [pqra_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // verdict[2:0]
    output logic [pqra_pkg::VERD_W-1:0]        o_m_axis_tuser
);
    pqra_pkg::t_cmd w_cmd;
    pqra_pkg::t_sts w_sts;

    pqra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pqra_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_BITS   (TICK_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );
endmodule
`default_nettype wire

// ===== rtl/core/pqra_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pqra_pkg.
`default_nettype none
module pqra_div (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire  [pqra_pkg::DIVD_W-1:0]       i_dividend,
    input  wire  [pqra_pkg::RATE_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [pqra_pkg::DIVD_W-1:0]       o_quot,
    output logic [pqra_pkg::RATE_W-1:0]       o_rem
);
    logic                          r_busy, r_done;
    logic [pqra_pkg::DCNT_W-1:0]   r_cnt;
    logic [pqra_pkg::RATE_W:0]     r_rem;
    logic [pqra_pkg::DIVD_W-1:0]   r_quo;
    logic [pqra_pkg::RATE_W:0]     w_t;
    logic                          w_ge;

    // The partial remainder stays below the divisor, so its top bit is always zero.
    assign w_t  = {r_rem[pqra_pkg::RATE_W-1:0], r_quo[pqra_pkg::DIVD_W-1]};
    assign w_ge = w_t >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pqra_pkg::DCNT_W'(pqra_pkg::DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pqra_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_t - {1'b0, i_divisor}) : w_t;
            r_quo <= {r_quo[pqra_pkg::DIVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem[pqra_pkg::RATE_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/pqra_ctrl.sv =====
// Sequencing state machine for enqueue and poll items.
// Depends on pqra_pkg.
`default_nettype none
module pqra_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  pqra_pkg::t_sts       i_sts,
    output pqra_pkg::t_cmd       o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_STQ    = 7'b0000010,
        S_WQ     = 7'b0000100,
        S_STL    = 7'b0001000,
        S_WL     = 7'b0010000,
        S_EVAL   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_STQ;
            end
            S_STQ: begin
                // A poll needs no division.
                o_cmd.div_start = !i_sts.poll;
                n_state = i_sts.poll ? S_EVAL : S_WQ;
            end
            S_WQ: begin
                o_cmd.save_q = i_sts.div_done;
                if (i_sts.div_done) n_state = S_STL;
            end
            S_STL: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_len = 1'b1;
                n_state = S_WL;
            end
            S_WL: begin
                o_cmd.save_l = i_sts.div_done;
                if (i_sts.div_done) n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/pqra_dp.sv =====
// Datapath: registers, pacing arithmetic, RED tests, descriptor memory, output register.
// Depends on pqra_pkg and pqra_div.
`default_nettype none
module pqra_dp #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int TICK_BITS   = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [pqra_pkg::CFGA_W-1:0]        i_cfg_addr,
    input  wire  [pqra_pkg::RATE_W-1:0]        i_cfg_wdata,
    input  wire  [pqra_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire  [pqra_pkg::IN_USER_W-1:0]     i_in_user,
    input  pqra_pkg::t_cmd                     i_cmd,
    output pqra_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [pqra_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic [pqra_pkg::VERD_W-1:0]        o_out_user
);
    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int DESC_W = pqra_pkg::TAG_W + pqra_pkg::LEN_W + TICK_BITS;
    localparam int SW     = (TICK_BITS > pqra_pkg::DIVD_W) ? TICK_BITS : pqra_pkg::DIVD_W;
    localparam int NW     = (TICK_BITS > pqra_pkg::NOW_W) ? TICK_BITS : pqra_pkg::NOW_W;
    localparam int PB_W   = pqra_pkg::RND_W + 1 + pqra_pkg::BYTES_W;
    localparam int PP_W   = pqra_pkg::RND_W + 1 + pqra_pkg::LIMP_W;

    function automatic logic tick_before(input logic [TICK_BITS-1:0] a,
                                         input logic [TICK_BITS-1:0] b);
        logic [TICK_BITS-1:0] d;
        d = a - b;
        return d[TICK_BITS-1];
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers.
    logic [pqra_pkg::RATE_W-1:0]  r_rate;
    logic [pqra_pkg::TPS_W-1:0]   r_tps;
    logic [pqra_pkg::LIMP_W-1:0]  r_lim_p;
    logic [pqra_pkg::MINP_W-1:0]  r_min_p;
    logic [pqra_pkg::BYTES_W-1:0] r_lim_b, r_min_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= pqra_pkg::RATE_RST;
            r_tps   <= pqra_pkg::TPS_RST;
            r_lim_p <= pqra_pkg::LIMP_RST;
            r_min_p <= pqra_pkg::MINP_RST;
            r_lim_b <= pqra_pkg::LIMB_RST;
            r_min_b <= pqra_pkg::MINB_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pqra_pkg::REG_RATE: r_rate  <= i_cfg_wdata;
                pqra_pkg::REG_TPS:  r_tps   <= i_cfg_wdata[pqra_pkg::TPS_W-1:0];
                pqra_pkg::REG_LIMP: r_lim_p <= i_cfg_wdata[pqra_pkg::LIMP_W-1:0];
                pqra_pkg::REG_MINP: r_min_p <= i_cfg_wdata[pqra_pkg::MINP_W-1:0];
                pqra_pkg::REG_LIMB: r_lim_b <= i_cfg_wdata[pqra_pkg::BYTES_W-1:0];
                pqra_pkg::REG_MINB: r_min_b <= i_cfg_wdata[pqra_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched input item.
    logic                          r_mode, r_lldp;
    logic [TICK_BITS-1:0]          r_now;
    logic [pqra_pkg::TAG_W-1:0]    r_tag;
    logic [pqra_pkg::LEN_W-1:0]    r_len;
    logic [pqra_pkg::RND_W-1:0]    r_rb, r_rp;
    logic [NW-1:0]                 w_now_ext;

    assign w_now_ext = NW'(i_in_data[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now  <= w_now_ext[TICK_BITS-1:0];
            r_tag  <= i_in_data[47:32];
            r_len  <= i_in_data[61:48];
            r_rb   <= i_in_data[69:62];
            r_rp   <= i_in_data[77:70];
            r_mode <= i_in_user[0];
            r_lldp <= i_in_user[1];
        end
    end

    // Block state.
    logic [TICK_BITS-1:0]          r_nst, n_nst;
    logic [pqra_pkg::RATE_W-1:0]   r_res, n_res;
    logic [pqra_pkg::BYTES_W-1:0]  r_bytes, n_bytes, r_avg_b, n_avg_b;
    logic [pqra_pkg::PKTS_W-1:0]   r_pkts, n_pkts, r_avg_p, n_avg_p;
    logic [AW-1:0]                 r_head, n_head, r_tail, n_tail;
    logic [pqra_pkg::CNT32_W-1:0]  r_hd, n_hd, r_cd, n_cd;
    logic [TICK_BITS-1:0]          r_due;

    // Divider and its saved results.
    logic                          w_div_done;
    logic [pqra_pkg::DIVD_W-1:0]   w_dividend, w_quot, r_q;
    logic [pqra_pkg::RATE_W-1:0]   w_divisor, w_rem, r_r, r_lrem;

    assign w_divisor  = (r_rate == '0) ? pqra_pkg::RATE_W'(1) : r_rate;
    assign w_dividend = i_cmd.div_sel_len ? pqra_pkg::DIVD_W'(r_len)
                      : pqra_pkg::DIVD_W'(r_res) + pqra_pkg::DIVD_W'(r_len);

    pqra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_q) begin
            r_q <= w_quot;
            r_r <= w_rem;
        end
        if (i_cmd.save_l) begin
            r_lrem <= w_rem;
        end
    end

    // RED thresholds: quotient > rnd is the same as (diff << 8) >= (rnd + 1) * span.
    logic [pqra_pkg::BYTES_W-1:0]  w_span_b;
    logic [pqra_pkg::LIMP_W-1:0]   w_span_p;
    logic [PB_W-1:0]               r_prod_b;
    logic [PP_W-1:0]               r_prod_p;

    assign w_span_b = (r_lim_b > r_min_b) ? (r_lim_b - r_min_b) : pqra_pkg::BYTES_W'(1);
    assign w_span_p = (r_lim_p > pqra_pkg::LIMP_W'(r_min_p))
                    ? (r_lim_p - pqra_pkg::LIMP_W'(r_min_p)) : pqra_pkg::LIMP_W'(1);

    always_ff @(posedge i_clk) begin
        r_prod_b <= PB_W'({1'b0, r_rb} + 9'd1) * PB_W'(w_span_b);
        r_prod_p <= PP_W'({1'b0, r_rp} + 9'd1) * PP_W'(w_span_p);
    end

    // Descriptor memory, read data registered from the head every cycle.
    logic [DESC_W-1:0] r_mem [QUEUE_DEPTH];
    logic [DESC_W-1:0] r_rd;
    logic              w_wr;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_tail] <= {r_due, r_len, r_tag};
        end
        r_rd <= r_mem[r_head];
    end

    // Decision, registered in the evaluate step.
    logic [SW-1:0]                 w_due_sum;
    logic [TICK_BITS-1:0]          w_due;
    logic [pqra_pkg::PKTS_W:0]     w_new_p;
    logic [pqra_pkg::BYTES_W:0]    w_new_b;
    logic                          w_pass, w_hard, w_red_b, w_red_p;
    logic [PB_W-1:0]               w_diff_b;
    logic [PP_W-1:0]               w_diff_p;
    logic [pqra_pkg::VERD_W-1:0]   r_verdict, w_verdict;
    logic                          r_restart;
    logic [TICK_BITS-1:0]          w_rd_rel;
    logic [pqra_pkg::TAG_W-1:0]    w_rd_tag;
    logic [pqra_pkg::LEN_W-1:0]    w_rd_len;

    assign {w_rd_rel, w_rd_len, w_rd_tag} = r_rd;
    assign w_due_sum = SW'(r_nst) + SW'(r_q);
    assign w_due     = w_due_sum[TICK_BITS-1:0];
    assign w_pass    = tick_before(w_due, r_now);
    assign w_new_p   = {1'b0, r_pkts} + 1'b1;
    assign w_new_b   = {1'b0, r_bytes} + (pqra_pkg::BYTES_W+1)'(r_len);
    assign w_hard    = (w_new_b > {1'b0, r_lim_b}) || (w_new_p > {1'b0, r_lim_p})
                    || (32'(w_new_p) > 32'(QUEUE_DEPTH));
    assign w_diff_b  = PB_W'({r_bytes - r_min_b, 8'd0});
    assign w_diff_p  = PP_W'({w_new_p - (pqra_pkg::PKTS_W+1)'(r_min_p), 8'd0});
    assign w_red_b   = (r_bytes > r_min_b) && (w_diff_b >= r_prod_b);
    assign w_red_p   = (w_new_p > (pqra_pkg::PKTS_W+1)'(r_min_p)) && (w_diff_p >= r_prod_p);

    always_comb begin
        if (r_mode) begin
            w_verdict = ((r_pkts != '0) && !tick_before(r_now, w_rd_rel))
                      ? pqra_pkg::V_RELEASED : pqra_pkg::V_NONE;
        end else if (w_pass) begin
            w_verdict = pqra_pkg::V_PASS;
        end else if (w_hard) begin
            w_verdict = pqra_pkg::V_HARD;
        end else if (!r_lldp && (w_red_b || w_red_p)) begin
            w_verdict = pqra_pkg::V_CONG;
        end else begin
            w_verdict = pqra_pkg::V_QUEUED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_verdict <= w_verdict;
            r_due     <= w_due;
            r_restart <= tick_before(r_nst + TICK_BITS'(r_tps), r_now);
        end
    end

    // Commit: next state and the result item.
    logic [pqra_pkg::BYTES_W-1:0]  w_lvl_b;
    logic [pqra_pkg::PKTS_W-1:0]   w_lvl_p;
    logic [pqra_pkg::BYTES_W+2:0]  w_ovl_b5;
    logic [pqra_pkg::PKTS_W+2:0]   w_ovl_p5;
    logic                          w_ovl;
    logic [TICK_BITS-1:0]          w_orel_t;
    logic [NW-1:0]                 w_orel_ext;
    logic [pqra_pkg::TAG_W-1:0]    w_otag;
    logic [pqra_pkg::LEN_W-1:0]    w_olen;

    always_comb begin
        n_nst   = r_nst;
        n_res   = r_res;
        n_bytes = r_bytes;
        n_pkts  = r_pkts;
        n_head  = r_head;
        n_tail  = r_tail;
        n_hd    = r_hd;
        n_cd    = r_cd;
        n_avg_b = r_avg_b;
        n_avg_p = r_avg_p;
        w_wr    = 1'b0;
        w_otag  = '0;
        w_olen  = '0;
        w_orel_t = '0;
        case (r_verdict)
            pqra_pkg::V_PASS: begin
                n_res = r_restart ? r_lrem : r_r;
                n_nst = r_now;
            end
            pqra_pkg::V_HARD: n_hd = r_hd + 1'b1;
            pqra_pkg::V_CONG: n_cd = r_cd + 1'b1;
            pqra_pkg::V_QUEUED: begin
                w_wr     = i_cmd.commit;
                n_tail   = ptr_inc(r_tail);
                n_pkts   = w_new_p[pqra_pkg::PKTS_W-1:0];
                n_bytes  = w_new_b[pqra_pkg::BYTES_W-1:0];
                n_nst    = r_due;
                n_res    = r_r;
                w_orel_t = r_due;
            end
            pqra_pkg::V_RELEASED: begin
                w_otag  = w_rd_tag;
                w_olen  = w_rd_len;
                n_bytes = (r_bytes >= pqra_pkg::BYTES_W'(w_rd_len))
                        ? r_bytes - pqra_pkg::BYTES_W'(w_rd_len) : '0;
                n_pkts  = r_pkts - 1'b1;
                n_head  = ptr_inc(r_head);
            end
            default: ;
        endcase
        w_lvl_b = n_bytes;
        w_lvl_p = n_pkts;
        // Averages move on every enqueue that does not pass straight through.
        if (!r_mode && (r_verdict != pqra_pkg::V_PASS)) begin
            n_avg_b = r_avg_b - (r_avg_b >> 1) + (w_lvl_b >> 1);
            n_avg_p = r_avg_p - (r_avg_p >> 1) + (w_lvl_p >> 1);
        end
    end

    // avg > floor(4 * limit / 5) is the same as 5 * avg > 4 * limit.
    assign w_ovl_b5   = (pqra_pkg::BYTES_W+3)'(n_avg_b) * (pqra_pkg::BYTES_W+3)'(5);
    assign w_ovl_p5   = (pqra_pkg::PKTS_W+3)'(n_avg_p) * (pqra_pkg::PKTS_W+3)'(5);
    assign w_ovl      = (w_ovl_b5 > {1'b0, r_lim_b, 2'b00})
                     || (w_ovl_p5 > {1'b0, r_lim_p, 2'b00});
    assign w_orel_ext = NW'(w_orel_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nst   <= TICK_BITS'(0) - TICK_BITS'(pqra_pkg::TPS_RST);
            r_res   <= '0;
            r_bytes <= '0;
            r_pkts  <= '0;
            r_avg_b <= '0;
            r_avg_p <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_hd    <= '0;
            r_cd    <= '0;
        end else if (i_cmd.commit) begin
            r_nst   <= n_nst;
            r_res   <= n_res;
            r_bytes <= n_bytes;
            r_pkts  <= n_pkts;
            r_avg_b <= n_avg_b;
            r_avg_p <= n_avg_p;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_hd    <= n_hd;
            r_cd    <= n_cd;
        end
    end

    // Output register.
    logic                                r_ovalid;
    logic [pqra_pkg::OUT_DATA_W-1:0]     r_odata;
    logic [pqra_pkg::VERD_W-1:0]         r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ouser <= r_verdict;
            r_odata <= {2'b00, n_cd, n_hd, w_ovl, n_bytes, n_pkts,
                        w_orel_ext[31:0], w_olen, w_otag};
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_data   = r_odata;
    assign o_out_user   = r_ouser;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_sts.poll     = r_mode;
endmodule
`default_nettype wire

// ===== rtl/core/pqra_checker.sv =====
// Port-level checker for the paced admission queue, bound to the top level.
// Depends on pqra_pkg and paced_queue_red_admission_top_defines.svh.
`default_nettype none
`include "paced_queue_red_admission_top_defines.svh"
module pqra_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_s_axis_tvalid,
    input wire                                o_s_axis_tready,
    input wire                                o_m_axis_tvalid,
    input wire                                i_m_axis_tready,
    input wire [pqra_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input wire [pqra_pkg::VERD_W-1:0]         o_m_axis_tuser
);
    // A stalled result keeps its contents.
    `PQRA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    // The block works on one item at a time.
    `PQRA_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // Verdict codes stop at nothing due.
    `PQRA_ASSERT_IMP(a_verdict, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser <= pqra_pkg::V_NONE)
    // Reset leaves no result pending.
    `PQRA_ASSERT_NXT(a_reset, i_clk, 1'b1, !i_rst_n, !o_m_axis_tvalid)
endmodule

bind paced_queue_red_admission_top pqra_checker u_pqra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for paced_queue_red_admission_top: pacing, hard and early drops.
// A local predictor works out each verdict and result; depends on pqra_pkg and the RTL only.
`timescale 1ns / 1ps
module tb;
    typedef struct {
        logic [pqra_pkg::VERD_W-1:0]  verdict;
        logic [pqra_pkg::TAG_W-1:0]   tag;
        logic [pqra_pkg::LEN_W-1:0]   len;
        logic [pqra_pkg::NOW_W-1:0]   rel;
        logic [pqra_pkg::PKTS_W-1:0]  pkts;
        logic [pqra_pkg::BYTES_W-1:0] bytes;
        logic                         ovl;
        logic [31:0]                  hard;
        logic [31:0]                  cong;
    } t_verdict;

    typedef struct {
        logic                         poll;
        logic [pqra_pkg::NOW_W-1:0]   now;
        logic [pqra_pkg::TAG_W-1:0]   tag;
        logic [pqra_pkg::LEN_W-1:0]   len;
        logic                         lldp;
        logic [pqra_pkg::RND_W-1:0]   rnd_b;
        logic [pqra_pkg::RND_W-1:0]   rnd_p;
    } t_pkt;

    localparam int DEPTH = 1024;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [pqra_pkg::CFGA_W-1:0]        cfg_addr = '0;
    logic [pqra_pkg::RATE_W-1:0]        cfg_wdata = '0;
    logic                               in_valid = 1'b0;
    wire                                in_ready;
    logic [pqra_pkg::IN_DATA_W-1:0]     in_data = '0;
    logic [pqra_pkg::IN_USER_W-1:0]     in_user = '0;
    wire                                out_valid;
    logic                               out_ready = 1'b0;
    wire [pqra_pkg::OUT_DATA_W-1:0]     out_data;
    wire [pqra_pkg::VERD_W-1:0]         out_user;

    paced_queue_red_admission_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_s_axis_tvalid(in_valid), .o_s_axis_tready(in_ready),
        .i_s_axis_tdata(in_data), .i_s_axis_tuser(in_user),
        .o_m_axis_tvalid(out_valid), .i_m_axis_tready(out_ready),
        .o_m_axis_tdata(out_data), .o_m_axis_tuser(out_user)
    );

    initial forever #4 i_clk = ~i_clk;

    // Predictor state.
    longint unsigned cfg_regs[6];
    logic [pqra_pkg::NOW_W-1:0] pace_tick;
    longint unsigned  residue, q_bytes, q_pkts, mean_bytes, mean_pkts;
    logic [31:0]      hard_cnt, cong_cnt;
    logic [pqra_pkg::TAG_W-1:0] fifo_tag[DEPTH];
    logic [pqra_pkg::LEN_W-1:0] fifo_len[DEPTH];
    logic [pqra_pkg::NOW_W-1:0] fifo_rel[DEPTH];
    int               fifo_head;

    t_verdict expected_verdicts[$];
    int       mismatch_count = 0;
    bit       no_gaps = 0;
    int       cycle_count = 0;
    logic [pqra_pkg::NOW_W-1:0] cur_now;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic bit tick_before(logic [pqra_pkg::NOW_W-1:0] a,
                                       logic [pqra_pkg::NOW_W-1:0] b);
        logic [pqra_pkg::NOW_W-1:0] d;
        d = a - b;
        return d[pqra_pkg::NOW_W-1];
    endfunction

    function automatic bit red_hit(longint unsigned minv, longint unsigned limit,
                                   longint unsigned level, longint unsigned rnd);
        longint unsigned div;
        if (level <= minv) return 0;
        div = (limit > minv) ? limit - minv : 1;
        return (((level - minv) << 8) / div) > rnd;
    endfunction

    function automatic t_verdict predict_admission(t_pkt p);
        t_verdict v;
        longint unsigned rate, req, qt, rm, np, nb;
        logic [pqra_pkg::NOW_W-1:0] due;
        int slot;
        v = '{default: '0};
        if (!p.poll) begin
            rate = cfg_regs[pqra_pkg::REG_RATE] != 0 ? cfg_regs[pqra_pkg::REG_RATE] : 1;
            req = residue + p.len;
            qt = req / rate;
            rm = req % rate;
            np = q_pkts + 1;
            nb = q_bytes + p.len;
            due = pace_tick + qt[pqra_pkg::NOW_W-1:0];
            if (tick_before(due, p.now)) begin
                if (tick_before(pace_tick + cfg_regs[pqra_pkg::REG_TPS][pqra_pkg::NOW_W-1:0],
                                p.now))
                    residue = p.len % rate;
                else
                    residue = rm;
                pace_tick = p.now;
                v.verdict = pqra_pkg::V_PASS;
            end else begin
                if (nb > cfg_regs[pqra_pkg::REG_LIMB] || np > cfg_regs[pqra_pkg::REG_LIMP] ||
                    np > DEPTH) begin
                    hard_cnt++;
                    v.verdict = pqra_pkg::V_HARD;
                end else if (!p.lldp &&
                             (red_hit(cfg_regs[pqra_pkg::REG_MINB], cfg_regs[pqra_pkg::REG_LIMB],
                                      q_bytes, p.rnd_b) ||
                              red_hit(cfg_regs[pqra_pkg::REG_MINP], cfg_regs[pqra_pkg::REG_LIMP],
                                      np, p.rnd_p))) begin
                    cong_cnt++;
                    v.verdict = pqra_pkg::V_CONG;
                end else begin
                    slot = (fifo_head + int'(q_pkts)) % DEPTH;
                    fifo_tag[slot] = p.tag;
                    fifo_len[slot] = p.len;
                    fifo_rel[slot] = due;
                    q_pkts = np;
                    q_bytes = nb;
                    pace_tick = due;
                    residue = rm;
                    v.rel = due;
                    v.verdict = pqra_pkg::V_QUEUED;
                end
                mean_bytes = mean_bytes - (mean_bytes >> 1) + (q_bytes >> 1);
                mean_pkts = mean_pkts - (mean_pkts >> 1) + (q_pkts >> 1);
            end
        end else if (q_pkts > 0 && !tick_before(p.now, fifo_rel[fifo_head])) begin
            v.tag = fifo_tag[fifo_head];
            v.len = fifo_len[fifo_head];
            q_bytes = (q_bytes >= v.len) ? q_bytes - v.len : 0;
            q_pkts--;
            fifo_head = (fifo_head + 1) % DEPTH;
            v.verdict = pqra_pkg::V_RELEASED;
        end else begin
            v.verdict = pqra_pkg::V_NONE;
        end
        v.pkts = q_pkts[pqra_pkg::PKTS_W-1:0];
        v.bytes = q_bytes[pqra_pkg::BYTES_W-1:0];
        v.ovl = (mean_pkts > cfg_regs[pqra_pkg::REG_LIMP] * 4 / 5) ||
                (mean_bytes > cfg_regs[pqra_pkg::REG_LIMB] * 4 / 5);
        v.hard = hard_cnt;
        v.cong = cong_cnt;
        return v;
    endfunction

    // Result side: random stalls and the field-by-field check.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_verdict w;
        int s;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result", out_user, 0);
            end else begin
                w = expected_verdicts.pop_front();
                if (out_user !== w.verdict) report_mismatch("verdict", out_user, w.verdict);
                if (out_data[15:0] !== w.tag) report_mismatch("out_tag", out_data[15:0], w.tag);
                if (out_data[29:16] !== w.len) report_mismatch("out_len", out_data[29:16], w.len);
                if (out_data[61:30] !== w.rel)
                    report_mismatch("release_tick", out_data[61:30], w.rel);
                if (out_data[72:62] !== w.pkts)
                    report_mismatch("queued_pkts", out_data[72:62], w.pkts);
                if (out_data[92:73] !== w.bytes)
                    report_mismatch("queued_bytes", out_data[92:73], w.bytes);
                if (out_data[93] !== w.ovl) report_mismatch("overloaded", out_data[93], w.ovl);
                if (out_data[125:94] !== w.hard)
                    report_mismatch("hard_drops", out_data[125:94], w.hard);
                if (out_data[157:126] !== w.cong)
                    report_mismatch("congestion_drops", out_data[157:126], w.cong);
            end
            s = no_gaps ? 0 : $urandom_range(0, 5);
            stall_left <= s;
            out_ready <= (s == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 1000000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(t_pkt p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_data <= {2'b00, p.rnd_p, p.rnd_b, p.len, p.tag, p.now};
        in_user <= {p.lldp, p.poll};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        expected_verdicts.push_back(predict_admission(p));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pqra_pkg::CFGA_W-1:0] idx, longint unsigned val);
        longint unsigned mask[6] = '{'h3FFFFF, 'h3FF, 'h7FF, 'h3FF, 'hFFFFF, 'hFFFFF};
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[pqra_pkg::RATE_W-1:0];
        @(posedge i_clk);
        cfg_regs[idx] = val & mask[idx];
        cfg_we <= 1'b0;
    endtask

    function automatic t_pkt enq(logic [pqra_pkg::NOW_W-1:0] now,
                                 logic [pqra_pkg::LEN_W-1:0] len);
        t_pkt p;
        p.poll = 0;
        p.now = now;
        p.tag = pqra_pkg::TAG_W'($urandom);
        p.len = len;
        p.lldp = ($urandom_range(0, 7) == 0);
        p.rnd_b = pqra_pkg::RND_W'($urandom);
        p.rnd_p = pqra_pkg::RND_W'($urandom);
        return p;
    endfunction

    function automatic t_pkt poll_at(logic [pqra_pkg::NOW_W-1:0] now);
        t_pkt p;
        p = enq(now, pqra_pkg::LEN_W'($urandom));
        p.poll = 1;
        p.lldp = 1'($urandom);
        return p;
    endfunction

    // Releases everything still queued by polling at or just after each head entry's release tick.
    task automatic drain_queue();
        while (q_pkts != 0) begin
            cur_now = fifo_rel[fifo_head] + $urandom_range(0, 3);
            send_item(poll_at(cur_now));
        end
    endtask

    task automatic test_directed();
        t_pkt p;
        cur_now = 32'd1000;
        p = enq(cur_now, pqra_pkg::LEN_W'(0));
        p.tag = 16'h0000; p.rnd_b = 8'h00; p.rnd_p = 8'h00; p.lldp = 0;
        send_item(p);                          // schedule behind: pass now
        p = enq(cur_now, pqra_pkg::LEN_W'(16383));
        p.tag = 16'hFFFF; p.rnd_b = 8'hFF; p.rnd_p = 8'hFF; p.lldp = 1;
        send_item(p);                          // queued behind the first one
        send_item(poll_at(cur_now));           // not yet due
        send_item(poll_at(fifo_rel[fifo_head])); // due exactly now
        send_item(poll_at(cur_now));           // empty queue
        wait_idle();
        // Tight limits so both hard and early drops fire; zero rate acts as one.
        write_reg(pqra_pkg::REG_RATE, 0);
        write_reg(pqra_pkg::REG_LIMP, 3);
        write_reg(pqra_pkg::REG_MINP, 0);
        write_reg(pqra_pkg::REG_LIMB, 20000);
        write_reg(pqra_pkg::REG_MINB, 0);
        cur_now = 32'hFFFF_FFF0;
        for (int i = 0; i < 8; i++) begin
            p = enq(cur_now, pqra_pkg::LEN_W'(2000 + i));
            p.lldp = i[0];
            p.rnd_b = 8'h00;
            p.rnd_p = 8'h00;
            send_item(p);
        end
        p = enq(cur_now, pqra_pkg::LEN_W'(16383));
        p.lldp = 1;
        send_item(p);                          // byte limit
        send_item(poll_at(32'h0000_0010));     // across the tick wrap
        drain_queue();
        wait_idle();
    endtask

    function automatic longint unsigned pick(longint unsigned lo, longint unsigned hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return lo + ($urandom % (hi - lo + 1));
        endcase
    endfunction

    task automatic test_random_phases();
        int n;
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 4))
                0: write_reg(pqra_pkg::REG_RATE, 0);
                1: write_reg(pqra_pkg::REG_RATE, 4194303);
                default: write_reg(pqra_pkg::REG_RATE, $urandom_range(40, 1500));
            endcase
            write_reg(pqra_pkg::REG_TPS, pick(1, 1000));
            write_reg(pqra_pkg::REG_LIMP, ph == 0 ? 1024 : pick(1, 1024));
            write_reg(pqra_pkg::REG_MINP, ph == 1 ? 1023 : pick(0, 1023));
            write_reg(pqra_pkg::REG_LIMB, ph == 2 ? 1 : (ph == 3 ? 1048575 : pick(1, 1048575)));
            write_reg(pqra_pkg::REG_MINB, ph == 4 ? 1048574 : pick(0, 1048575));
            no_gaps = (ph % 3 == 2);
            cur_now = $urandom;
            n = 0;
            while (n < 250) begin
                case ($urandom_range(0, 19))
                    0: cur_now = cur_now + $urandom_range(1000, 3000);
                    1: cur_now = $urandom;
                    default: cur_now = cur_now + $urandom_range(0, 2);
                endcase
                if ($urandom_range(0, 99) < 55)
                    send_item(enq(cur_now, pqra_pkg::LEN_W'(($urandom_range(0, 15) == 0) ?
                                           16383 : $urandom_range(0, 3000))));
                else
                    send_item(poll_at(cur_now));
                n++;
            end
            drain_queue();
            wait_idle();
        end
    endtask

    initial begin
        cfg_regs = '{320, 250, 1024, 512, 49152, 12288};
        pace_tick = -32'd250;
        residue = 0; q_bytes = 0; q_pkts = 0; mean_bytes = 0; mean_pkts = 0;
        hard_cnt = 0; cong_cnt = 0; fifo_head = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
